// ----- design/bea_pkg.sv -----
// shared types and constants for the game pad edge detector with auto-repeat
package bea_pkg;

   // fixed widths of the stream and register fields
   localparam int BTN_W       = 16;
   localparam int STICK_W     = 8;
   localparam int CFG_W       = 8;
   localparam int CSR_ADDR_W  = 1;
   localparam int REQ_DATA_W  = 32;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 80;

   // reset values of the repeat timing
   localparam logic [CFG_W-1:0] DELAY_RESET    = 8'd30;
   localparam logic [CFG_W-1:0] INTERVAL_RESET = 8'd5;
   localparam logic [CFG_W-1:0] COUNTER_RESET  = 8'd30;

   // item kind carried in tuser
   typedef enum logic {
      FUNC_POLL    = 1'b0,
      FUNC_CONSUME = 1'b1
   } func_type;

   // register indexes of the csr port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_REPEAT_DELAY    = 1'b0,
      CSR_REPEAT_INTERVAL = 1'b1
   } csr_addr_type;

   typedef struct packed {
      logic [CFG_W-1:0] repeat_delay;
      logic [CFG_W-1:0] repeat_interval;
   } cfg_type;

   typedef struct packed {
      func_type                   func;
      logic                       pad_error;
      logic [BTN_W-1:0]           buttons;
      logic signed [STICK_W-1:0]  stick_x_in;
      logic signed [STICK_W-1:0]  stick_y_in;
   } req_item_type;

   // last member sits in the lowest bits, so this packs straight onto tdata
   typedef struct packed {
      logic signed [STICK_W-1:0]  stick_y_out;
      logic signed [STICK_W-1:0]  stick_x_out;
      logic [BTN_W-1:0]           repeat_out;
      logic [BTN_W-1:0]           released_out;
      logic [BTN_W-1:0]           pressed_out;
      logic [BTN_W-1:0]           held_out;
   } rsp_item_type;

endpackage

// ----- design/bea_core.sv -----
// pad state, edge detection, repeat countdown and sticky accumulators
module bea_core
   import bea_pkg::*;
#(
   parameter int BUTTON_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  req_item_type  item,
   input  cfg_type       cfg,
   output rsp_item_type  result
);

   logic [BUTTON_BITS-1:0]     held_ff, held_in;
   logic [BUTTON_BITS-1:0]     acc_pr_ff, acc_pr_in;
   logic [BUTTON_BITS-1:0]     acc_rl_ff, acc_rl_in;
   logic [BUTTON_BITS-1:0]     acc_rp_ff, acc_rp_in;
   logic [CFG_W-1:0]           count_ff, count_in;
   logic signed [STICK_W-1:0]  stick_x_ff, stick_x_in;
   logic signed [STICK_W-1:0]  stick_y_ff, stick_y_in;
   logic                       error_ff, error_in;

   logic [BUTTON_BITS-1:0]     b, diff, pr, rl, rp;
   logic [CFG_W-1:0]           count_poll;

   // sample masked to the button count
   assign b    = BUTTON_BITS'(item.buttons);
   assign diff = b ^ held_ff;
   assign pr   = diff & b;
   assign rl   = diff & held_ff;

   // repeat countdown: reload on change, fire at one or zero
   always_comb begin
      if (diff != '0) begin
         rp         = pr;
         count_poll = cfg.repeat_delay;
      end else if (count_ff >= CFG_W'(2)) begin
         rp         = '0;
         count_poll = count_ff - CFG_W'(1);
      end else begin
         rp         = b;
         count_poll = cfg.repeat_interval;
      end
   end

   // next state and result word
   always_comb begin
      held_in    = held_ff;
      acc_pr_in  = acc_pr_ff;
      acc_rl_in  = acc_rl_ff;
      acc_rp_in  = acc_rp_ff;
      count_in   = count_ff;
      stick_x_in = stick_x_ff;
      stick_y_in = stick_y_ff;
      error_in   = error_ff;
      result     = '0;
      case (item.func)
         FUNC_POLL: begin
            error_in = item.pad_error;
            if (item.pad_error) begin
               // failed read keeps everything but the error flag, shows the stored pad
               result.held_out    = BTN_W'(held_ff);
               result.stick_x_out = stick_x_ff;
               result.stick_y_out = stick_y_ff;
            end else begin
               held_in    = b;
               count_in   = count_poll;
               stick_x_in = item.stick_x_in;
               stick_y_in = item.stick_y_in;
               acc_pr_in  = acc_pr_ff | pr;
               acc_rl_in  = acc_rl_ff | rl;
               acc_rp_in  = acc_rp_ff | rp;
               result.held_out     = BTN_W'(b);
               result.pressed_out  = BTN_W'(pr);
               result.released_out = BTN_W'(rl);
               result.repeat_out   = BTN_W'(rp);
               result.stick_x_out  = item.stick_x_in;
               result.stick_y_out  = item.stick_y_in;
            end
         end
         FUNC_CONSUME: begin
            // pad in error reads as all zeros
            if (!error_ff) begin
               result.held_out     = BTN_W'(held_ff);
               result.pressed_out  = BTN_W'(acc_pr_ff);
               result.released_out = BTN_W'(acc_rl_ff);
               result.repeat_out   = BTN_W'(acc_rp_ff);
               result.stick_x_out  = stick_x_ff;
               result.stick_y_out  = stick_y_ff;
            end
            acc_pr_in = '0;
            acc_rl_in = '0;
            acc_rp_in = '0;
         end
         default: begin
         end
      endcase
   end

   // state registers, updated once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         acc_pr_ff  <= '0;
         acc_rl_ff  <= '0;
         acc_rp_ff  <= '0;
         count_ff   <= COUNTER_RESET;
         stick_x_ff <= '0;
         stick_y_ff <= '0;
         error_ff   <= 1'b0;
      end else if (step) begin
         held_ff    <= held_in;
         acc_pr_ff  <= acc_pr_in;
         acc_rl_ff  <= acc_rl_in;
         acc_rp_ff  <= acc_rp_in;
         count_ff   <= count_in;
         stick_x_ff <= stick_x_in;
         stick_y_ff <= stick_y_in;
         error_ff   <= error_in;
      end
   end

endmodule

// ----- design/button_edge_autorepeat.sv -----
// top level: input register, pad logic, output register and csr registers
//
// Game pad edge detector with auto-repeat. Each accepted word gives exactly one
// response word; a poll word returns this poll's edges and repeats, a consume
// word returns the accumulated ones and clears them. One word is taken every
// cycle while rsp_tready is high: an input register feeds the pad logic, whose
// result lands in an output register, so a new word is accepted while a
// finished one still waits for rsp_tready. The user must write the csr registers
// only while no word is in flight; the block itself does not enforce it.
module button_edge_autorepeat
   import bea_pkg::*;
#(
   parameter int BUTTON_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // buttons, stick_x_in, stick_y_in
   input  logic [REQ_USER_W-1:0]  req_tuser,   // func, pad_error
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // held_out, pressed_out, released_out, repeat_out, stick_x_out, stick_y_out
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CFG_W-1:0]       csr_wdata
);

   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff;
   req_item_type  req_item;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_item_ff;
   rsp_item_type  result;
   cfg_type       cfg_ff;
   logic          advance;
   logic          req_accept;

   // unpack the request word
   assign req_item.func       = func_type'(req_tuser[0]);
   assign req_item.pad_error  = req_tuser[1];
   assign req_item.buttons    = req_tdata[BTN_W-1:0];
   assign req_item.stick_x_in = req_tdata[BTN_W+STICK_W-1:BTN_W];
   assign req_item.stick_y_in = req_tdata[BTN_W+2*STICK_W-1:BTN_W+STICK_W];

   // handshake
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_accept  = req_tvalid && req_tready;
   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = out_item_ff;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // input and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_delay    <= DELAY_RESET;
         cfg_ff.repeat_interval <= INTERVAL_RESET;
      end else if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_REPEAT_DELAY:    cfg_ff.repeat_delay    <= csr_wdata;
            CSR_REPEAT_INTERVAL: cfg_ff.repeat_interval <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bea_core #(
      .BUTTON_BITS (BUTTON_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

endmodule

// ----- design/bea_checker.sv -----
// port-level checker for the pad block and its bind to the top level
module bea_checker
   import bea_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata
);

   logic [1:0]  pending_ff, pending_in;
   logic        req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // words accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no response right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // every response answers an accepted word
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("response without a pending request word");

   // two words in flight and a stalled output leave no room
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == 2'd2 && !rsp_tready) |-> !req_tready)
      else $error("request taken while both stages are full");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response dropped or changed while stalled");

endmodule

bind button_edge_autorepeat bea_checker u_bea_checker (.*);

// ----- tb/testbench.sv -----
// self-checking testbench for the game pad edge detector with auto-repeat
`timescale 1ns / 100ps

module testbench;
   import bea_pkg::*;

   localparam int DIR_ROWS    = 30;
   localparam int NUM_PHASES  = 7;
   localparam int STALL_LIMIT = 2000;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CFG  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      csr_addr_type     addr;
      logic [CFG_W-1:0] val;
      func_type         func;
      logic             err;
      logic [BTN_W-1:0] btn;
      logic [7:0]       sx;
      logic [7:0]       sy;
      logic             chk;
      rsp_item_type     want;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // buttons, stick_x_in, stick_y_in
   logic [REQ_USER_W-1:0] req_tuser = '0;   // func, pad_error
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // held_out, pressed_out, released_out, repeat_out, stick_x_out, stick_y_out
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CFG_W-1:0]      csr_wdata = '0;

   // predicted pad state and timing registers
   logic [CFG_W-1:0] cfg_delay    = DELAY_RESET;
   logic [CFG_W-1:0] cfg_interval = INTERVAL_RESET;
   logic [BTN_W-1:0] held         = '0;
   logic [8:0]       rpt_count    = 9'd30;
   logic [BTN_W-1:0] acc_pressed  = '0;
   logic [BTN_W-1:0] acc_released = '0;
   logic [BTN_W-1:0] acc_repeat   = '0;
   logic [7:0]       stick_x      = '0;
   logic [7:0]       stick_y      = '0;
   logic             pad_err      = 1'b0;

   rsp_item_type pad_rsp_q [$];
   rsp_item_type got_rsp;
   rsp_item_type want_rsp;
   dir_row_type  dir_tab [DIR_ROWS];
   int           mismatches = 0;
   int           stall_cycles = 0;
   bit           calm = 1'b0;

   button_edge_autorepeat dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_item_type rsp_word(logic [BTN_W-1:0] h, logic [BTN_W-1:0] pr,
                                             logic [BTN_W-1:0] rl, logic [BTN_W-1:0] rp,
                                             logic [7:0] sx, logic [7:0] sy);
      rsp_item_type r;
      r.held_out     = h;
      r.pressed_out  = pr;
      r.released_out = rl;
      r.repeat_out   = rp;
      r.stick_x_out  = sx;
      r.stick_y_out  = sy;
      return r;
   endfunction

   // advance the pad state by one word and return its response
   function automatic rsp_item_type pad_predict(func_type f, logic err, logic [BTN_W-1:0] b,
                                                logic [7:0] sx, logic [7:0] sy);
      logic [BTN_W-1:0] diff;
      logic [BTN_W-1:0] pr;
      logic [BTN_W-1:0] rl;
      logic [BTN_W-1:0] rp;
      rsp_item_type     r;
      if (f == FUNC_POLL) begin
         pad_err = err;
         if (err) begin
            return rsp_word(held, '0, '0, '0, stick_x, stick_y);
         end
         diff = b ^ held;
         pr   = diff & b;
         rl   = diff & held;
         // any change reloads the delay, steady polls count down to a repeat
         if (diff != '0) begin
            rp        = pr;
            rpt_count = {1'b0, cfg_delay};
         end else if (rpt_count >= 9'd2) begin
            rp        = '0;
            rpt_count = rpt_count - 9'd1;
         end else begin
            rp        = b;
            rpt_count = {1'b0, cfg_interval};
         end
         held         = b;
         stick_x      = sx;
         stick_y      = sy;
         acc_pressed  = acc_pressed | pr;
         acc_released = acc_released | rl;
         acc_repeat   = acc_repeat | rp;
         return rsp_word(held, pr, rl, rp, stick_x, stick_y);
      end
      // consume: snapshot, blanked in error, then clear the accumulators
      r = pad_err ? rsp_item_type'('0)
                  : rsp_word(held, acc_pressed, acc_released, acc_repeat, stick_x, stick_y);
      acc_pressed  = '0;
      acc_released = '0;
      acc_repeat   = '0;
      return r;
   endfunction

   function automatic dir_row_type poll_row(logic err, logic [BTN_W-1:0] b, logic [7:0] sx,
                                            logic [7:0] sy, logic chk, rsp_item_type want);
      return '{ROW_ITEM, CSR_REPEAT_DELAY, '0, FUNC_POLL, err, b, sx, sy, chk, want};
   endfunction

   function automatic dir_row_type cons_row(logic chk, rsp_item_type want);
      return '{ROW_ITEM, CSR_REPEAT_DELAY, '0, FUNC_CONSUME, 1'b0, '0, '0, '0, chk, want};
   endfunction

   function automatic dir_row_type cfg_row(csr_addr_type a, logic [CFG_W-1:0] v);
      return '{ROW_CFG, a, v, FUNC_POLL, 1'b0, '0, '0, '0, 1'b0, '0};
   endfunction

   // present one word, wait for acceptance, then record its expected response
   task automatic send_word(func_type f, logic err, logic [BTN_W-1:0] b, logic [7:0] sx,
                            logic [7:0] sy, logic chk, rsp_item_type want);
      rsp_item_type pred;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {sy, sx, b};
      req_tuser  <= {err, f};
      do @(posedge clock); while (!req_tready);
      pred = pad_predict(f, err, b, sx, sy);
      pad_rsp_q.push_back(chk ? want : pred);
   endtask

   // stop sending and wait until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pad_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic cfg_write(csr_addr_type a, logic [CFG_W-1:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= v;
      @(posedge clock);
      if (a == CSR_REPEAT_DELAY) cfg_delay = v;
      else cfg_interval = v;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // runs of steady buttons with random sticks, sprinkled with consumes and bad reads
   task automatic run_phase(int n);
      int               sent;
      int               len;
      int               roll;
      logic [BTN_W-1:0] pat;
      sent = 0;
      pat  = held;
      while (sent < n) begin
         case ($urandom_range(0, 4))
            0: pat = BTN_W'($urandom);
            1: pat = 16'h0001 << $urandom_range(0, 15);
            2: pat = pat ^ (16'h0001 << $urandom_range(0, 15));
            3: pat = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: pat = pat;
         endcase
         if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 8);
         else len = $urandom_range(1, cfg_delay + 2 * cfg_interval + 4);
         for (int k = 0; k < len && sent < n; k++) begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
               send_word(FUNC_POLL, 1'b1, BTN_W'($urandom), 8'($urandom), 8'($urandom),
                         1'b0, '0);
            else if (roll < 3)
               send_word(FUNC_CONSUME, 1'($urandom_range(0, 1)), BTN_W'($urandom),
                         8'($urandom), 8'($urandom), 1'b0, '0);
            else
               send_word(FUNC_POLL, 1'b0, pat, 8'($urandom), 8'($urandom), 1'b0, '0);
            sent++;
         end
      end
   endtask

   // response side: ready bursts broken by random stalls
   initial begin
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         if (calm) begin
            @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 24)) @(posedge clock);
            if (!calm) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
      end
   end

   // compare each response word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = rsp_tdata;
         if (pad_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", rsp_tdata);
         end else begin
            want_rsp = pad_rsp_q.pop_front();
            if (got_rsp.held_out !== want_rsp.held_out ||
                got_rsp.pressed_out !== want_rsp.pressed_out ||
                got_rsp.released_out !== want_rsp.released_out ||
                got_rsp.repeat_out !== want_rsp.repeat_out ||
                got_rsp.stick_x_out !== want_rsp.stick_x_out ||
                got_rsp.stick_y_out !== want_rsp.stick_y_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch held/pr/rl/rp/sx/sy exp %h %h %h %h %h %h",
                            " got %h %h %h %h %h %h"},
                           want_rsp.held_out, want_rsp.pressed_out, want_rsp.released_out,
                           want_rsp.repeat_out, want_rsp.stick_x_out, want_rsp.stick_y_out,
                           got_rsp.held_out, got_rsp.pressed_out, got_rsp.released_out,
                           got_rsp.repeat_out, got_rsp.stick_x_out, got_rsp.stick_y_out);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // main sequence
   initial begin
      logic [CFG_W-1:0] ph_delay [NUM_PHASES];
      logic [CFG_W-1:0] ph_interval [NUM_PHASES];
      int               ph_items [NUM_PHASES];

      // directed words: reset snapshot, extremes, bad reads, short repeat timings
      dir_tab[0]  = cons_row(1'b1, rsp_word('0, '0, '0, '0, '0, '0));
      dir_tab[1]  = poll_row(1'b0, 16'hFFFF, 8'h7F, 8'h80, 1'b1,
                             rsp_word(16'hFFFF, 16'hFFFF, '0, 16'hFFFF, 8'h7F, 8'h80));
      dir_tab[2]  = poll_row(1'b0, 16'h0000, 8'h80, 8'h7F, 1'b1,
                             rsp_word('0, '0, 16'hFFFF, '0, 8'h80, 8'h7F));
      // bad read keeps the stored sample
      dir_tab[3]  = poll_row(1'b1, 16'h1234, 8'h11, 8'h22, 1'b1,
                             rsp_word('0, '0, '0, '0, 8'h80, 8'h7F));
      // consume while in error is blanked
      dir_tab[4]  = cons_row(1'b1, rsp_word('0, '0, '0, '0, '0, '0));
      dir_tab[5]  = poll_row(1'b0, 16'h0000, 8'h00, 8'h00, 1'b0, '0);
      dir_tab[6]  = cons_row(1'b0, '0);
      // zero delay and unit interval: repeat on every steady poll
      dir_tab[7]  = cfg_row(CSR_REPEAT_DELAY, 8'd0);
      dir_tab[8]  = cfg_row(CSR_REPEAT_INTERVAL, 8'd1);
      dir_tab[9]  = poll_row(1'b0, 16'h8001, 8'h01, 8'hFF, 1'b0, '0);
      dir_tab[10] = poll_row(1'b0, 16'h8001, 8'h02, 8'hFE, 1'b0, '0);
      dir_tab[11] = poll_row(1'b0, 16'h8001, 8'h03, 8'hFD, 1'b0, '0);
      dir_tab[12] = cons_row(1'b0, '0);
      // short delay, zero interval: counter reaches zero
      dir_tab[13] = cfg_row(CSR_REPEAT_DELAY, 8'd2);
      dir_tab[14] = cfg_row(CSR_REPEAT_INTERVAL, 8'd0);
      dir_tab[15] = poll_row(1'b0, 16'h0100, 8'h40, 8'hC0, 1'b0, '0);
      dir_tab[16] = poll_row(1'b0, 16'h0100, 8'h41, 8'hC1, 1'b0, '0);
      dir_tab[17] = poll_row(1'b0, 16'h0100, 8'h42, 8'hC2, 1'b0, '0);
      dir_tab[18] = poll_row(1'b0, 16'h0100, 8'h43, 8'hC3, 1'b0, '0);
      dir_tab[19] = poll_row(1'b0, 16'h0100, 8'h44, 8'hC4, 1'b0, '0);
      dir_tab[20] = cons_row(1'b0, '0);
      dir_tab[21] = poll_row(1'b1, 16'hFFFF, 8'h7F, 8'h7F, 1'b0, '0);
      dir_tab[22] = poll_row(1'b1, 16'h0000, 8'h80, 8'h80, 1'b0, '0);
      dir_tab[23] = cons_row(1'b0, '0);
      dir_tab[24] = poll_row(1'b0, 16'h5555, 8'h01, 8'hFF, 1'b0, '0);
      dir_tab[25] = poll_row(1'b0, 16'hAAAA, 8'h81, 8'h7F, 1'b0, '0);
      dir_tab[26] = poll_row(1'b0, 16'hAAAA, 8'h00, 8'h00, 1'b0, '0);
      dir_tab[27] = cons_row(1'b0, '0);
      dir_tab[28] = poll_row(1'b0, 16'h0000, 8'hFF, 8'h01, 1'b0, '0);
      dir_tab[29] = cons_row(1'b0, '0);

      // timing settings per random phase, extremes first
      ph_delay    = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd0, 8'd0, 8'd30};
      ph_interval = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd0, 8'd0, 8'd5};
      ph_items    = '{150, 150, 350, 200, 200, 200, 200};
      ph_delay[4]    = CFG_W'($urandom_range(2, 40));
      ph_interval[4] = CFG_W'($urandom_range(0, 12));
      ph_delay[5]    = CFG_W'($urandom_range(2, 40));
      ph_interval[5] = CFG_W'($urandom_range(0, 12));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_tab[i].kind == ROW_CFG) begin
            drain();
            cfg_write(dir_tab[i].addr, dir_tab[i].val);
         end else begin
            send_word(dir_tab[i].func, dir_tab[i].err, dir_tab[i].btn, dir_tab[i].sx,
                      dir_tab[i].sy, dir_tab[i].chk, dir_tab[i].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         cfg_write(CSR_REPEAT_DELAY, ph_delay[p]);
         cfg_write(CSR_REPEAT_INTERVAL, ph_interval[p]);
         calm = (p == NUM_PHASES - 1);
         run_phase(ph_items[p]);
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
